### rtl/tife_pkg.sv
// Shared types and constants for the tagged integer field encoder.
// Holds the type codes, the field frame layout and the stream widths.
// No dependencies.
`default_nettype none

package tife_pkg;

  // Header type codes, one per payload size
  localparam logic [3:0] TYPE_INT8  = 4'd0;
  localparam logic [3:0] TYPE_INT16 = 4'd1;
  localparam logic [3:0] TYPE_INT32 = 4'd2;
  localparam logic [3:0] TYPE_INT64 = 4'd3;
  localparam logic [3:0] TYPE_ZERO  = 4'd12;

  // Tags from this value up go out in a separate byte
  localparam logic [7:0] TAG_ESCAPE = 8'd15;

  // Worst case bytes per field: header, tag byte, eight payload bytes
  localparam int FRAME_MAX = 10;
  localparam int COUNT_W   = $clog2(FRAME_MAX + 1);

  // Stream widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  // One encoded field, byte 0 goes out first
  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        count;
  } frame_t;

endpackage

`default_nettype wire

### rtl/tagged_integer_field_encoder.sv
// Path: stage 1, stage 2, stage 3, the serializer, then the output register.
// Throughput: one byte per cycle on the output while m_tready is high; a field is 1 to 10
// bytes (header, optional tag byte, 0/1/2/4/8 payload bytes), sent by the byte-wide
// serializer. A new request enters every cycle while the serializer keeps up.
// Reset: synchronous, active high; clears all valid bits, the byte counter and tvalid.
// Depends on tife_pkg.
`default_nettype none

module tagged_integer_field_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input request stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [tife_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] field_tag, [71:8] field_value
  // Output byte stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [tife_pkg::OUT_DATA_W-1:0]      m_tdata,  // [7:0] out_byte
  output logic                                 m_tlast   // last_byte
);

  // Stage 1: captured request
  logic        s1_valid;
  logic [7:0]  s1_tag;
  logic [63:0] s1_value;
  logic        s1_ready;

  // Stage 2: classified request
  logic        s2_valid;
  logic [7:0]  s2_tag;
  logic [63:0] s2_value;
  logic [3:0]  s2_type;
  logic [3:0]  s2_nbytes;
  logic        s2_esc;
  logic        s2_ready;

  // Stage 3: assembled frame
  logic              s3_valid;
  tife_pkg::frame_t  s3_frame;
  tife_pkg::frame_t  frame_next;
  logic              s3_ready;

  // Serializer
  logic [tife_pkg::FRAME_MAX-1:0][7:0] sh_bytes;
  logic [tife_pkg::COUNT_W-1:0]        sh_left;
  logic                                sh_load;
  logic                                out_load;

  // Classification of the stage 1 value
  logic       is_zero;
  logic       fits8;
  logic       fits16;
  logic       fits32;
  logic [3:0] type_next;
  logic [3:0] nbytes_next;

  // Handshake chain: a stage takes new data when empty or when it is passing data on
  assign out_load = (!m_tvalid || m_tready) && (sh_left != '0);
  assign sh_load  = s3_valid &&
                    ((sh_left == '0) ||
                     ((sh_left == tife_pkg::COUNT_W'(1)) && out_load));
  assign s3_ready = !s3_valid || sh_load;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s_tready = s1_ready;

  // Stage 1: capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
    if (s1_ready && s_tvalid) begin
      s1_tag   <= s_tdata[7:0];
      s1_value <= s_tdata[71:8];
    end
  end

  // Pick the narrowest signed width that holds the value
  always_comb begin
    is_zero = (s1_value == 64'd0);
    fits8   = (&s1_value[63:7])  || (~|s1_value[63:7]);
    fits16  = (&s1_value[63:15]) || (~|s1_value[63:15]);
    fits32  = (&s1_value[63:31]) || (~|s1_value[63:31]);
    if (is_zero) begin
      type_next   = tife_pkg::TYPE_ZERO;
      nbytes_next = 4'd0;
    end else if (fits8) begin
      type_next   = tife_pkg::TYPE_INT8;
      nbytes_next = 4'd1;
    end else if (fits16) begin
      type_next   = tife_pkg::TYPE_INT16;
      nbytes_next = 4'd2;
    end else if (fits32) begin
      type_next   = tife_pkg::TYPE_INT32;
      nbytes_next = 4'd4;
    end else begin
      type_next   = tife_pkg::TYPE_INT64;
      nbytes_next = 4'd8;
    end
  end

  // Stage 2: hold classification
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_tag    <= s1_tag;
      s2_value  <= s1_value;
      s2_type   <= type_next;
      s2_nbytes <= nbytes_next;
      s2_esc    <= (s1_tag >= tife_pkg::TAG_ESCAPE);
    end
  end

  // Assemble header, optional tag byte and big-endian payload
  always_comb begin
    logic [7:0][7:0] pay;
    logic [7:0]      header;
    pay = '0;
    unique case (s2_type)
      tife_pkg::TYPE_INT8: begin
        pay[0] = s2_value[7:0];
      end
      tife_pkg::TYPE_INT16: begin
        for (int k = 0; k < 2; k++) pay[k] = s2_value[15 - 8*k -: 8];
      end
      tife_pkg::TYPE_INT32: begin
        for (int k = 0; k < 4; k++) pay[k] = s2_value[31 - 8*k -: 8];
      end
      tife_pkg::TYPE_INT64: begin
        for (int k = 0; k < 8; k++) pay[k] = s2_value[63 - 8*k -: 8];
      end
      default: begin
        pay = '0;
      end
    endcase
    header = {(s2_esc ? tife_pkg::TAG_ESCAPE[3:0] : s2_tag[3:0]), s2_type};
    frame_next.bytes    = '0;
    frame_next.bytes[0] = header;
    if (s2_esc) begin
      frame_next.bytes[1] = s2_tag;
      for (int j = 2; j < tife_pkg::FRAME_MAX; j++) frame_next.bytes[j] = pay[j-2];
    end else begin
      for (int j = 1; j < tife_pkg::FRAME_MAX - 1; j++) frame_next.bytes[j] = pay[j-1];
    end
    frame_next.count = tife_pkg::COUNT_W'(1) + tife_pkg::COUNT_W'(s2_esc)
                     + tife_pkg::COUNT_W'(s2_nbytes);
  end

  // Stage 3: hold assembled frame
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      s3_frame <= frame_next;
    end
  end

  // Serializer: load a frame, then shift one byte out per output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_left <= '0;
    end else if (sh_load) begin
      sh_left <= s3_frame.count;
    end else if (out_load) begin
      sh_left <= sh_left - tife_pkg::COUNT_W'(1);
    end
    if (sh_load) begin
      sh_bytes <= s3_frame.bytes;
    end else if (out_load) begin
      sh_bytes <= {8'h00, sh_bytes[tife_pkg::FRAME_MAX-1:1]};
    end
  end

  // Output register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= (sh_left != '0);
    end
    if (out_load) begin
      m_tdata <= sh_bytes[0];
      m_tlast <= (sh_left == tife_pkg::COUNT_W'(1));
    end
  end

`ifndef SYNTHESIS
  // A frame in stage 3 always holds 1 to 10 bytes
  assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_frame.count != '0) &&
                 (s3_frame.count <= tife_pkg::COUNT_W'(tife_pkg::FRAME_MAX)))
    else $error("frame byte count out of range");

  // Bytes of one field follow without gaps
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a field");

  // A stalled stage 1 request is held, not dropped
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_value) && $stable(s1_tag))
    else $error("stage 1 request lost under stall");

  // The serializer never holds more than one frame's worth of bytes
  assert property (@(posedge clk) disable iff (rst)
    sh_left <= tife_pkg::COUNT_W'(tife_pkg::FRAME_MAX))
    else $error("serializer count out of range");
`endif

endmodule

`default_nettype wire
